/* src/ssd_pkg.sv */
// Shared types, constants and helpers for the slot span detector.
// No dependencies; imported by ssd_judge, slot_span_detector_top, ssd_span_checker and testbench.
package ssd_pkg;

  localparam int unsigned MaxRowWidth = 4096;
  localparam int unsigned ColW        = $clog2(MaxRowWidth);
  localparam int unsigned PixW        = 8;
  localparam int unsigned CntW        = 13;
  localparam int unsigned SumW        = 14;
  localparam int unsigned CfgDataW    = 14;
  localparam int unsigned SpanW       = 12;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SOLID_VALUE      = 3'd0,
    REG_SLOT_VALUE       = 3'd1,
    REG_FRAME_MIN_EACH   = 3'd2,
    REG_FRAME_MIN_EITHER = 3'd3,
    REG_FRAME_MIN_SUM    = 3'd4,
    REG_EDGE_MIN_EACH    = 3'd5,
    REG_EDGE_MIN_EITHER  = 3'd6,
    REG_EDGE_MIN_SUM     = 3'd7
  } ssd_reg_e;

  // Scan phase, one-hot
  typedef enum logic [3:0] {
    PH_SEEK  = 4'b0001,
    PH_OPEN  = 4'b0010,
    PH_GAP   = 4'b0100,
    PH_CLOSE = 4'b1000
  } ssd_phase_e;

  typedef struct packed {
    logic [PixW-1:0] pixel_above;
    logic [PixW-1:0] pixel_centre;
    logic [PixW-1:0] pixel_below;
    logic            row_last;
  } ssd_in_t;

  typedef struct packed {
    logic [SpanW-1:0] span_first;
    logic [SpanW-1:0] span_final;
  } ssd_out_t;

  typedef struct packed {
    logic [PixW-1:0] solid_value;
    logic [PixW-1:0] slot_value;
    logic [CntW-1:0] frame_min_each;
    logic [CntW-1:0] frame_min_either;
    logic [SumW-1:0] frame_min_sum;
    logic [CntW-1:0] edge_min_each;
    logic [CntW-1:0] edge_min_either;
    logic [SumW-1:0] edge_min_sum;
  } ssd_cfg_t;

  // Measurements handed to the threshold checker
  typedef struct packed {
    logic [CntW-1:0]        gap_len;
    logic [CntW-1:0]        open_len;
    logic [CntW-1:0]        close_len;
    logic [1:0][CntW-1:0]   open_run;
    logic [1:0][CntW-1:0]   close_run;
  } ssd_meas_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? v : v + CntW'(1);
  endfunction

endpackage

/* src/ssd_judge.sv */
// Eight threshold tests deciding whether a measured slot is a fill span.
// Depends on ssd_pkg.
module ssd_judge (
  input  ssd_pkg::ssd_cfg_t  cfg_i,
  input  ssd_pkg::ssd_meas_t meas_i,
  output logic               ok_o
);
  import ssd_pkg::*;

  logic [CntW-1:0] sa, sb;
  logic [SumW-1:0] frame_sum, edge_sum;
  logic            frame_ok, edge_ok;

  assign sa = (meas_i.open_run[0] > meas_i.open_run[1]) ?
              meas_i.open_run[0] : meas_i.open_run[1];
  assign sb = (meas_i.close_run[0] > meas_i.close_run[1]) ?
              meas_i.close_run[0] : meas_i.close_run[1];

  assign frame_sum = SumW'(meas_i.open_len) + SumW'(meas_i.close_len);
  assign edge_sum  = SumW'(sa) + SumW'(sb);

  assign frame_ok = (meas_i.open_len  >= cfg_i.frame_min_each) &&
                    (meas_i.close_len >= cfg_i.frame_min_each) &&
                    ((meas_i.open_len  >= cfg_i.frame_min_either) ||
                     (meas_i.close_len >= cfg_i.frame_min_either)) &&
                    (frame_sum >= cfg_i.frame_min_sum);

  assign edge_ok  = (sa >= cfg_i.edge_min_each) && (sb >= cfg_i.edge_min_each) &&
                    ((sa >= cfg_i.edge_min_either) || (sb >= cfg_i.edge_min_either)) &&
                    (edge_sum >= cfg_i.edge_min_sum);

  assign ok_o = (meas_i.gap_len != '0) && frame_ok && edge_ok;

endmodule

/* src/slot_span_detector_top.sv */
// Slot span detector top level: input register, scan state, result register.
// Depends on ssd_pkg and ssd_judge.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | sink      | in_valid_i / in_ready_o   | in_req_i  (ssd_in_t)
//  out     | source    | out_valid_o / out_ready_i | out_req_o (ssd_out_t)
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request per clock sustained while the result register is not stalled. A
// request waits in the input register until the result slot is free or being
// drained; then the scan state and the span result register update together.
// Reset (rst_ni low, async) clears the scan state, valids and config to defaults.
// A stalled result holds in the output register; the input register keeps
// taking requests while the result slot is free or being drained.
module slot_span_detector_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ssd_pkg::ssd_in_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ssd_pkg::ssd_out_t  out_req_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  ssd_pkg::ssd_reg_e  cfg_index_i,
  input  logic [ssd_pkg::CfgDataW-1:0] cfg_data_i
);
  import ssd_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers; always ready; unguarded, user writes only while idle
  // ---------------------------------------------------------------------------
  ssd_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{solid_value: 8'hFF, default: '0};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SOLID_VALUE:      cfg_q.solid_value      <= cfg_data_i[PixW-1:0];
        REG_SLOT_VALUE:       cfg_q.slot_value       <= cfg_data_i[PixW-1:0];
        REG_FRAME_MIN_EACH:   cfg_q.frame_min_each   <= cfg_data_i[CntW-1:0];
        REG_FRAME_MIN_EITHER: cfg_q.frame_min_either <= cfg_data_i[CntW-1:0];
        REG_FRAME_MIN_SUM:    cfg_q.frame_min_sum    <= cfg_data_i[SumW-1:0];
        REG_EDGE_MIN_EACH:    cfg_q.edge_min_each    <= cfg_data_i[CntW-1:0];
        REG_EDGE_MIN_EITHER:  cfg_q.edge_min_either  <= cfg_data_i[CntW-1:0];
        REG_EDGE_MIN_SUM:     cfg_q.edge_min_sum     <= cfg_data_i[SumW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register stage
  // ---------------------------------------------------------------------------
  logic    s1_valid_q;
  ssd_in_t s1_req_q;
  logic    out_valid_q;
  ssd_out_t out_req_q;
  logic    adv;

  // Stage 1 moves on when the result slot is empty or being drained.
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_req_q <= in_req_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Scan state
  // ---------------------------------------------------------------------------
  ssd_phase_e            phase_q, phase_d;
  logic [ColW-1:0]       col_q, col_d;
  logic [CntW-1:0]       open_len_q, open_len_d;
  logic [CntW-1:0]       gap_len_q, gap_len_d;
  logic [CntW-1:0]       close_len_q, close_len_d;
  logic [SpanW-1:0]      gap_start_q, gap_start_d;
  logic [SpanW-1:0]      gap_end_q, gap_end_d;
  logic [1:0][CntW-1:0]  open_run_q, open_run_d;
  logic [1:0][CntW-1:0]  close_run_q, close_run_d;
  logic [1:0]            close_done_q, close_done_d;
  logic [1:0][CntW-1:0]  next_run_q, next_run_d;

  logic [1:0][PixW-1:0]  nb;
  logic                  is_solid, is_slot, last;
  logic [1:0]            nb_slot;
  logic                  fire, judge_ok;
  ssd_meas_t             meas;
  logic [SpanW-1:0]      span_final;

  assign nb[0]      = s1_req_q.pixel_above;
  assign nb[1]      = s1_req_q.pixel_below;
  assign is_solid   = (s1_req_q.pixel_centre == cfg_q.solid_value);
  assign is_slot    = (s1_req_q.pixel_centre == cfg_q.slot_value);
  assign nb_slot[0] = (nb[0] == cfg_q.slot_value);
  assign nb_slot[1] = (nb[1] == cfg_q.slot_value);
  // overlong rows end at the last column the index can hold
  assign last       = s1_req_q.row_last || (col_q == ColW'(MaxRowWidth - 1));

  always_comb begin
    phase_d      = phase_q;
    col_d        = col_q + ColW'(1);
    open_len_d   = open_len_q;
    gap_len_d    = gap_len_q;
    close_len_d  = close_len_q;
    gap_start_d  = gap_start_q;
    gap_end_d    = gap_end_q;
    open_run_d   = open_run_q;
    close_run_d  = close_run_q;
    close_done_d = close_done_q;
    next_run_d   = next_run_q;
    fire         = 1'b0;
    span_final   = gap_end_q;

    // judge sees the open side as it stands; close side set per case below
    meas.gap_len   = gap_len_q;
    meas.open_len  = open_len_q;
    meas.open_run  = open_run_q;
    meas.close_len = close_len_q;
    meas.close_run = close_run_q;

    case (phase_q)
      PH_SEEK: begin
        if (is_solid) begin
          open_len_d = CntW'(1);
          open_run_d = '0;
          phase_d    = PH_OPEN;
        end
      end
      PH_OPEN: begin
        if (is_slot) begin
          gap_start_d = SpanW'(col_q);
          gap_len_d   = '0;
          phase_d     = PH_GAP;
        end else begin
          open_len_d = sat_inc(open_len_q);
          for (int i = 0; i < 2; i++) begin
            open_run_d[i] = nb_slot[i] ? sat_inc(open_run_q[i]) : '0;
          end
        end
      end
      PH_GAP: begin
        if (is_solid) begin
          // gap closed: closing frame starts empty
          gap_end_d      = SpanW'(col_q);
          span_final     = SpanW'(col_q);
          close_len_d    = '0;
          close_run_d    = '0;
          close_done_d   = '0;
          next_run_d     = '0;
          phase_d        = PH_CLOSE;
          meas.close_len = '0;
          meas.close_run = '0;
          fire           = last;
        end else begin
          gap_len_d = sat_inc(gap_len_q);
        end
      end
      PH_CLOSE: begin
        if (is_slot) begin
          // next slot: closing frame becomes the opening frame
          fire        = 1'b1;
          open_len_d  = close_len_q;
          open_run_d  = next_run_q;
          gap_start_d = SpanW'(col_q);
          gap_len_d   = '0;
          phase_d     = PH_GAP;
        end else begin
          close_len_d = sat_inc(close_len_q);
          for (int i = 0; i < 2; i++) begin
            if (!close_done_q[i]) begin
              if (nb_slot[i]) close_run_d[i] = sat_inc(close_run_q[i]);
              else            close_done_d[i] = 1'b1;
            end
            next_run_d[i] = nb_slot[i] ? sat_inc(next_run_q[i]) : '0;
          end
          meas.close_len = close_len_d;
          meas.close_run = close_run_d;
          fire           = last;
        end
      end
      default: begin
        phase_d = PH_SEEK;
      end
    endcase

    // end of row: everything back to its start value
    if (last) begin
      phase_d      = PH_SEEK;
      col_d        = '0;
      open_len_d   = '0;
      gap_len_d    = '0;
      close_len_d  = '0;
      gap_start_d  = '0;
      gap_end_d    = '0;
      open_run_d   = '0;
      close_run_d  = '0;
      close_done_d = '0;
      next_run_d   = '0;
    end
  end

  ssd_judge u_judge (
    .cfg_i  (cfg_q),
    .meas_i (meas),
    .ok_o   (judge_ok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SEEK;
      col_q        <= '0;
      open_len_q   <= '0;
      gap_len_q    <= '0;
      close_len_q  <= '0;
      gap_start_q  <= '0;
      gap_end_q    <= '0;
      open_run_q   <= '0;
      close_run_q  <= '0;
      close_done_q <= '0;
      next_run_q   <= '0;
    end else if (adv) begin
      phase_q      <= phase_d;
      col_q        <= col_d;
      open_len_q   <= open_len_d;
      gap_len_q    <= gap_len_d;
      close_len_q  <= close_len_d;
      gap_start_q  <= gap_start_d;
      gap_end_q    <= gap_end_d;
      open_run_q   <= open_run_d;
      close_run_q  <= close_run_d;
      close_done_q <= close_done_d;
      next_run_q   <= next_run_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fire && judge_ok;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && fire && judge_ok) begin
      out_req_q.span_first <= gap_start_q;
      out_req_q.span_final <= span_final;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

/* tb/ssd_span_checker.sv */
`timescale 1ns / 100ps
// Span checker for the slot span detector: tracks config writes, predicts spans
// from accepted pixel requests and compares them with the result channel. Needs ssd_pkg.
module ssd_span_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  ssd_pkg::ssd_in_t             in_req_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  ssd_pkg::ssd_out_t            out_req_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  ssd_pkg::ssd_reg_e            cfg_index_i,
  input  logic [ssd_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                  pending_o,
  output int unsigned                  errors_o
);
  import ssd_pkg::*;

  localparam logic [ColW-1:0] LastCol = ColW'(MaxRowWidth - 1);
  localparam logic [CntW-1:0] RunTop  = {CntW{1'b1}};

  ssd_cfg_t        lim;
  ssd_phase_e      scan_state;
  logic [ColW-1:0] col;
  logic [CntW-1:0] open_len, gap_len, close_len;
  logic [ColW-1:0] gap_first, gap_final, next_first;
  logic [CntW-1:0] open_run  [2];
  logic [CntW-1:0] close_run [2];
  logic [CntW-1:0] next_run  [2];
  logic            close_done[2];

  ssd_out_t        span_q[$];
  int unsigned     errors = 0;

  function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] v);
    return (v == RunTop) ? v : v + 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns span check: %s got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic clear_row();
    scan_state = PH_SEEK;
    col        = '0;
    open_len   = '0;
    gap_len    = '0;
    close_len  = '0;
    gap_first  = '0;
    gap_final  = '0;
    next_first = '0;
    for (int i = 0; i < 2; i++) begin
      open_run[i]   = '0;
      close_run[i]  = '0;
      next_run[i]   = '0;
      close_done[i] = 1'b0;
    end
  endtask

  // Eight threshold tests on the current frames and edge runs
  task automatic judge_span();
    int unsigned a, b, sa, sb;
    ssd_out_t    e;
    a  = open_len;
    b  = close_len;
    sa = (open_run[0] > open_run[1]) ? open_run[0] : open_run[1];
    sb = (close_run[0] > close_run[1]) ? close_run[0] : close_run[1];
    if (gap_len != 0 &&
        a >= lim.frame_min_each && b >= lim.frame_min_each &&
        (a >= lim.frame_min_either || b >= lim.frame_min_either) &&
        a + b >= lim.frame_min_sum &&
        sa >= lim.edge_min_each && sb >= lim.edge_min_each &&
        (sa >= lim.edge_min_either || sb >= lim.edge_min_either) &&
        sa + sb >= lim.edge_min_sum) begin
      e.span_first = gap_first;
      e.span_final = gap_final;
      span_q.push_back(e);
    end
  endtask

  task automatic predict_column(input ssd_in_t px);
    logic [PixW-1:0] nb[2];
    logic            is_last;
    logic            nb_slot;
    nb[0]   = px.pixel_above;
    nb[1]   = px.pixel_below;
    is_last = px.row_last || (col == LastCol);
    case (scan_state)
      PH_SEEK: begin
        if (px.pixel_centre == lim.solid_value) begin
          open_len    = CntW'(1);
          open_run[0] = '0;
          open_run[1] = '0;
          scan_state  = PH_OPEN;
        end
      end
      PH_OPEN: begin
        if (px.pixel_centre == lim.slot_value) begin
          gap_first  = col;
          gap_len    = '0;
          scan_state = PH_GAP;
        end else begin
          open_len = bump(open_len);
          for (int i = 0; i < 2; i++)
            open_run[i] = (nb[i] == lim.slot_value) ? bump(open_run[i]) : '0;
        end
      end
      PH_GAP: begin
        if (px.pixel_centre == lim.solid_value) begin
          gap_final = col;
          close_len = '0;
          for (int i = 0; i < 2; i++) begin
            close_run[i]  = '0;
            close_done[i] = 1'b0;
            next_run[i]   = '0;
          end
          scan_state = PH_CLOSE;
          if (is_last) judge_span();
        end else begin
          gap_len = bump(gap_len);
        end
      end
      default: begin
        if (px.pixel_centre == lim.slot_value) begin
          // closing frame hands over as the next opening frame
          judge_span();
          next_first  = col;
          open_len    = close_len;
          open_run[0] = next_run[0];
          open_run[1] = next_run[1];
          gap_first   = next_first;
          gap_len     = '0;
          scan_state  = PH_GAP;
        end else begin
          close_len = bump(close_len);
          for (int i = 0; i < 2; i++) begin
            nb_slot = (nb[i] == lim.slot_value);
            if (!close_done[i]) begin
              if (nb_slot) close_run[i] = bump(close_run[i]);
              else close_done[i] = 1'b1;
            end
            next_run[i] = nb_slot ? bump(next_run[i]) : '0;
          end
          if (is_last) judge_span();
        end
      end
    endcase
    if (is_last) clear_row();
    else col = col + 1'b1;
  endtask

  always @(posedge clk_i) begin
    ssd_out_t want;
    if (!rst_ni) begin
      clear_row();
      lim             = '0;
      lim.solid_value = 8'hFF;
      span_q.delete();
    end else begin
      // compare first: a span leaving now belongs to an older request
      if (out_valid_i && out_ready_i) begin
        if (span_q.size() == 0) begin
          report_mismatch("span with none pending, first", out_req_i.span_first, 0);
        end else begin
          want = span_q.pop_front();
          if (out_req_i.span_first !== want.span_first)
            report_mismatch("span_first", out_req_i.span_first, want.span_first);
          if (out_req_i.span_final !== want.span_final)
            report_mismatch("span_final", out_req_i.span_final, want.span_final);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SOLID_VALUE:      lim.solid_value      = cfg_data_i[PixW-1:0];
          REG_SLOT_VALUE:       lim.slot_value       = cfg_data_i[PixW-1:0];
          REG_FRAME_MIN_EACH:   lim.frame_min_each   = cfg_data_i[CntW-1:0];
          REG_FRAME_MIN_EITHER: lim.frame_min_either = cfg_data_i[CntW-1:0];
          REG_FRAME_MIN_SUM:    lim.frame_min_sum    = cfg_data_i[SumW-1:0];
          REG_EDGE_MIN_EACH:    lim.edge_min_each    = cfg_data_i[CntW-1:0];
          REG_EDGE_MIN_EITHER:  lim.edge_min_either  = cfg_data_i[CntW-1:0];
          REG_EDGE_MIN_SUM:     lim.edge_min_sum     = cfg_data_i[SumW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_column(in_req_i);
    end
    pending_o <= span_q.size();
    errors_o  <= errors;
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Top of the slot span detector regression: clock, reset, pixel and config stimulus,
// random back-pressure and the verdict. Needs ssd_pkg, ssd_span_checker and the block.
module testbench;
  import ssd_pkg::*;

  // Longest stretch without any request moving before the run is declared hung.
  // Covers the long receiver hold-off plus random stalls with wide margin.
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned HoldCycles   = 300;  // one long receiver hold-off
  localparam int unsigned SettleCycles = 8;    // settle time for requests that yield no span
  localparam int unsigned RandomItems  = 1900;
  localparam int unsigned PhaseCount   = 6;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  ssd_in_t             in_req    = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ssd_out_t            out_req;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  ssd_reg_e            cfg_index = REG_SOLID_VALUE;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int unsigned pending;
  int unsigned errors;

  // Stimulus knobs. send_idle_pct belongs to the stimulus process; recv_idle_pct
  // and hold_req are written with nonblocking assignments for the receiver.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  ssd_cfg_t    cur_cfg;
  int unsigned sent_cnt      = 0;
  int unsigned stall_cycles  = 0;
  int unsigned hold_left     = 0;
  bit          hold_taken    = 1'b0;

  always #5 clk = ~clk;

  slot_span_detector_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_req_o   (out_req),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  ssd_span_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_req_i   (out_req),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // Receiver: random stalls, plus one long hold-off on request from the stimulus.
  // During the hold the sender keeps offering, so the result register fills
  // and the block has to stall its pixel input.
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HoldCycles;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any request moving on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("slot_span_detector_top regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic ssd_cfg_t reset_limits();
    ssd_cfg_t c;
    c             = '0;
    c.solid_value = 8'hFF;
    c.slot_value  = 8'h00;
    return c;
  endfunction

  // Distinct solid and slot values, low thresholds so spans still pass often
  function automatic ssd_cfg_t random_limits();
    ssd_cfg_t c;
    c.solid_value = PixW'($urandom_range(255));
    do c.slot_value = PixW'($urandom_range(255)); while (c.slot_value == c.solid_value);
    c.frame_min_each   = CntW'($urandom_range(3));
    c.frame_min_either = CntW'($urandom_range(6));
    c.frame_min_sum    = SumW'($urandom_range(10));
    c.edge_min_each    = CntW'($urandom_range(1));
    c.edge_min_either  = CntW'($urandom_range(3));
    c.edge_min_sum     = SumW'($urandom_range(4));
    return c;
  endfunction

  // Pixel value drawn as solid, slot or anything, by percentage
  function automatic logic [PixW-1:0] shade(input int unsigned solid_pct,
                                            input int unsigned slot_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < solid_pct) return cur_cfg.solid_value;
    if (r < solid_pct + slot_pct) return cur_cfg.slot_value;
    return PixW'($urandom_range(255));
  endfunction

  // One pixel request; valid stays up until taken, payload held
  task automatic send_column(input ssd_in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic send_px(input logic [PixW-1:0] above, input logic [PixW-1:0] centre,
                         input logic [PixW-1:0] below, input logic last);
    ssd_in_t px;
    px.pixel_above  = above;
    px.pixel_centre = centre;
    px.pixel_below  = below;
    px.row_last     = last;
    send_column(px);
  endtask

  // Writes all eight registers back to back, lowers valid once at the end
  task automatic load_config(input ssd_cfg_t c);
    ssd_reg_e            r;
    logic [CfgDataW-1:0] val;
    r = r.first();
    do begin
      case (r)
        REG_SOLID_VALUE:      val = CfgDataW'(c.solid_value);
        REG_SLOT_VALUE:       val = CfgDataW'(c.slot_value);
        REG_FRAME_MIN_EACH:   val = CfgDataW'(c.frame_min_each);
        REG_FRAME_MIN_EITHER: val = CfgDataW'(c.frame_min_either);
        REG_FRAME_MIN_SUM:    val = CfgDataW'(c.frame_min_sum);
        REG_EDGE_MIN_EACH:    val = CfgDataW'(c.edge_min_each);
        REG_EDGE_MIN_EITHER:  val = CfgDataW'(c.edge_min_either);
        REG_EDGE_MIN_SUM:     val = CfgDataW'(c.edge_min_sum);
        default:              val = '0;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data  <= val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      r = r.next();
    end while (r != r.first());
    cfg_valid <= 1'b0;
    cur_cfg = c;
  endtask

  // Idle the input, wait out every pending span, then the pipeline latency:
  // a request that yields no span may still be in flight.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Tidy rows alternate solid and slot runs with a little noise, so most rows
  // get deep into the gap and closing frame. Untidy rows are plain noise with
  // row ends at random. An endless row never sets row_last and relies on the
  // column limit to wrap.
  task automatic send_row(input int unsigned width, input bit tidy, input bit endless);
    ssd_in_t     px;
    bit          in_solid;
    int unsigned run_left;
    in_solid = ($urandom_range(1) != 0);
    run_left = $urandom_range(1, 6);
    for (int c = 0; c < width; c++) begin
      if (tidy) begin
        if (run_left == 0) begin
          in_solid = !in_solid;
          run_left = $urandom_range(1, 6);
        end
        run_left--;
        px.pixel_centre = in_solid ? shade(90, 0) : shade(0, 90);
        px.pixel_above  = shade(15, 65);
        px.pixel_below  = shade(15, 65);
        px.row_last     = !endless && (c == width - 1);
      end else begin
        px.pixel_centre = shade(35, 35);
        px.pixel_above  = shade(35, 35);
        px.pixel_below  = shade(35, 35);
        px.row_last     = ($urandom_range(19) == 0);
      end
      send_column(px);
    end
  endtask

  task automatic run_rows(input int unsigned goal);
    while (sent_cnt < goal) begin
      if ($urandom_range(99) < 80) send_row($urandom_range(3, 28), 1'b1, 1'b0);
      else send_row($urandom_range(1, 16), 1'b0, 1'b0);
    end
  endtask

  initial begin
    ssd_cfg_t    lim;
    int unsigned goal;
    int unsigned base;
    cur_cfg       = reset_limits();
    send_idle_pct = 24;
    recv_idle_pct <= 60;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows on reset config (solid 255, slot 0, no thresholds).
    // Slot of two, closed, then a slot pixel in the closing frame: span 1..3;
    // the second gap has no length and the row ends right on its close.
    send_px(8'h00, 8'hFF, 8'h00, 1'b0);
    send_px(8'hFF, 8'h00, 8'hFF, 1'b0);
    send_px(8'h00, 8'h00, 8'h00, 1'b0);
    send_px(8'h00, 8'hFF, 8'h00, 1'b0);
    send_px(8'h00, 8'h00, 8'hFF, 1'b0);
    send_px(8'hFF, 8'hFF, 8'h00, 1'b1);
    // row that ends inside the gap: nothing
    send_px(8'h00, 8'hFF, 8'h00, 1'b0);
    send_px(8'h00, 8'h00, 8'h00, 1'b0);
    send_px(8'h00, 8'h00, 8'h00, 1'b1);
    // row that ends in the closing frame: judged at the last pixel
    send_px(8'h00, 8'hFF, 8'h00, 1'b0);
    send_px(8'h00, 8'h00, 8'h00, 1'b0);
    send_px(8'h00, 8'h00, 8'h00, 1'b0);
    send_px(8'h00, 8'hFF, 8'h00, 1'b0);
    send_px(8'hFF, 8'hFF, 8'hFF, 1'b1);
    // one-column row of neither value, then a row with a non-solid lead-in
    send_px(8'hFF, 8'h33, 8'h00, 1'b1);
    send_px(8'hFF, 8'h80, 8'h00, 1'b0);
    send_px(8'h00, 8'hFF, 8'h00, 1'b0);
    send_px(8'h00, 8'hFF, 8'h00, 1'b0);
    send_px(8'hFF, 8'h00, 8'hFF, 1'b0);
    send_px(8'h00, 8'h00, 8'h00, 1'b0);
    send_px(8'h00, 8'hFF, 8'h00, 1'b0);
    send_px(8'h00, 8'hFF, 8'hFF, 1'b1);
    drain();

    // solid and slot equal: each phase tests the value it seeks first
    lim             = '0;
    lim.solid_value = 8'h5A;
    lim.slot_value  = 8'h5A;
    load_config(lim);
    send_px(8'h5A, 8'h5A, 8'h5A, 1'b0);
    send_px(8'h5A, 8'h5A, 8'h5A, 1'b0);
    send_px(8'h00, 8'h11, 8'h5A, 1'b0);
    send_px(8'h5A, 8'h5A, 8'h5A, 1'b0);
    send_px(8'h5A, 8'h22, 8'h5A, 1'b0);
    send_px(8'h5A, 8'h5A, 8'h5A, 1'b0);
    send_px(8'h5A, 8'h5A, 8'h5A, 1'b1);
    drain();

    // Random part: two phases per idle profile, each with its own config
    base = sent_cnt;
    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 24; recv_idle_pct <= 60; end
        1: begin send_idle_pct = 60; recv_idle_pct <= 24; end
        default: begin send_idle_pct = 0; recv_idle_pct <= 0; end
      endcase
      case (ph)
        0: lim = reset_limits();
        2: begin
          lim                  = '0;
          lim.solid_value      = 8'h00;
          lim.slot_value       = 8'hFF;
          lim.frame_min_each   = 1;
          lim.frame_min_either = 3;
          lim.frame_min_sum    = 5;
          lim.edge_min_either  = 1;
          lim.edge_min_sum     = 1;
        end
        3: begin
          // every threshold above the longest row: no slot passes
          lim.solid_value      = 8'hFF;
          lim.slot_value       = 8'h00;
          lim.frame_min_each   = 4096;
          lim.frame_min_either = 4096;
          lim.frame_min_sum    = 8192;
          lim.edge_min_each    = 4096;
          lim.edge_min_either  = 4096;
          lim.edge_min_sum     = 8192;
        end
        4: begin
          lim             = '0;
          lim.solid_value = PixW'($urandom_range(255));
          lim.slot_value  = lim.solid_value;
        end
        default: lim = random_limits();
      endcase
      load_config(lim);
      if (ph == 0) begin
        // spans come often here, so the long hold-off backs the block up
        run_rows(sent_cnt + 60);
        hold_req <= 1'b1;
      end
      goal = base + (ph + 1) * RandomItems / PhaseCount;
      run_rows(goal);
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("slot_span_detector_top regression: pass");
    end else begin
      $display("slot_span_detector_top regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
src/ssd_pkg.sv
src/ssd_judge.sv
src/slot_span_detector_top.sv
tb/ssd_span_checker.sv
tb/testbench.sv
